// ----- rtl/core/dfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_pkg
// Shared types and constants of the depth flicker detector.
// ----------------------------------------------------------------------------
package dfd_pkg;

	localparam int DEPTH_W    = 16;
	localparam int SCORE_W    = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 10;
	localparam int FLAG_THR_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = WIDTH_W + HEIGHT_W;

	localparam logic [SCORE_W-1:0] SCORE_MAX = 8'd255;

	localparam logic [WIDTH_W-1:0]    FRAME_WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0]   FRAME_HEIGHT_RST = 10'd480;
	localparam logic [DEPTH_W-1:0]    CHANGE_THR_RST   = 16'd50;
	localparam logic [FLAG_THR_W-1:0] FLAG_THR_RST     = 8'd5;

	// output buffer entries, also the number of items allowed in flight
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = 3;
	localparam int OUTQ_CW    = 4;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_CHANGE_THR   = 2'd2,
		CFG_FLAG_THR     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic last;
		logic primed;
	} px_ctl_t;

	typedef struct packed {
		logic flag;
		logic last;
	} res_t;

endpackage

// ----- rtl/core/dfd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_ctrl
// Configuration registers, frame size, pixel position and priming state.
// ----------------------------------------------------------------------------
module dfd_ctrl #(
	parameter int MAX_PIXELS = 524288
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_idx,
	input  logic [dfd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 accept,
	output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] idx,
	output dfd_pkg::px_ctl_t                     ctl,
	output logic [dfd_pkg::DEPTH_W-1:0]          change_thr,
	output logic [dfd_pkg::FLAG_THR_W-1:0]       flag_thr
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam logic [31:0] MAXP = 32'(MAX_PIXELS);

	// last position of a frame of prod pixels, saturated, empty frame is one pixel
	function automatic logic [AW-1:0] last_index(input logic [31:0] prod);
		logic [31:0] t;
		if (prod == 32'd0) begin
			t = 32'd0;
		end else if (prod > MAXP) begin
			t = MAXP - 32'd1;
		end else begin
			t = prod - 32'd1;
		end
		return t[AW-1:0];
	endfunction

	localparam logic [AW-1:0] LAST_RST =
		last_index(32'(dfd_pkg::FRAME_WIDTH_RST) * 32'(dfd_pkg::FRAME_HEIGHT_RST));

	logic [dfd_pkg::WIDTH_W-1:0]    width_q;
	logic [dfd_pkg::HEIGHT_W-1:0]   height_q;
	logic [dfd_pkg::DEPTH_W-1:0]    change_thr_q;
	logic [dfd_pkg::FLAG_THR_W-1:0] flag_thr_q;
	logic [AW-1:0]                  last_idx_q;
	logic [AW-1:0]                  idx_q;
	logic                           primed_q;

	logic [dfd_pkg::WIDTH_W-1:0]  w_sel;
	logic [dfd_pkg::HEIGHT_W-1:0] h_sel;
	logic [dfd_pkg::PROD_W-1:0]   prod;
	logic                         size_wr;
	logic                         at_last;

	// size product uses the value being written and the other stored dimension
	always_comb begin
		w_sel = width_q;
		h_sel = height_q;
		if (cfg_idx == dfd_pkg::CFG_FRAME_WIDTH) begin
			w_sel = cfg_wdata[dfd_pkg::WIDTH_W-1:0];
		end
		if (cfg_idx == dfd_pkg::CFG_FRAME_HEIGHT) begin
			h_sel = cfg_wdata[dfd_pkg::HEIGHT_W-1:0];
		end
		prod = dfd_pkg::PROD_W'(w_sel) * dfd_pkg::PROD_W'(h_sel);
		size_wr = cfg_we && (cfg_idx == dfd_pkg::CFG_FRAME_WIDTH ||
			cfg_idx == dfd_pkg::CFG_FRAME_HEIGHT);
		at_last = (idx_q == last_idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= dfd_pkg::FRAME_WIDTH_RST;
			height_q     <= dfd_pkg::FRAME_HEIGHT_RST;
			change_thr_q <= dfd_pkg::CHANGE_THR_RST;
			flag_thr_q   <= dfd_pkg::FLAG_THR_RST;
			last_idx_q   <= LAST_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				dfd_pkg::CFG_FRAME_WIDTH: begin
					width_q <= cfg_wdata[dfd_pkg::WIDTH_W-1:0];
				end
				dfd_pkg::CFG_FRAME_HEIGHT: begin
					height_q <= cfg_wdata[dfd_pkg::HEIGHT_W-1:0];
				end
				dfd_pkg::CFG_CHANGE_THR: begin
					change_thr_q <= cfg_wdata[dfd_pkg::DEPTH_W-1:0];
				end
				dfd_pkg::CFG_FLAG_THR: begin
					flag_thr_q <= cfg_wdata[dfd_pkg::FLAG_THR_W-1:0];
				end
				default: begin
				end
			endcase
			if (size_wr) begin
				last_idx_q <= last_index(32'(prod));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			primed_q <= 1'b0;
		end else if (size_wr) begin
			idx_q    <= '0;
			primed_q <= 1'b0;
		end else if (accept) begin
			if (at_last) begin
				idx_q    <= '0;
				primed_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign idx        = idx_q;
	assign ctl.last   = at_last;
	assign ctl.primed = primed_q;
	assign change_thr = change_thr_q;
	assign flag_thr   = flag_thr_q;

endmodule

// ----- rtl/core/dfd_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_pipe
// Per-pixel history memory and the three-stage score update pipeline.
// ----------------------------------------------------------------------------
module dfd_pipe #(
	parameter int MAX_PIXELS = 524288
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [dfd_pkg::DEPTH_W-1:0]          depth_in,
	input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] idx_in,
	input  dfd_pkg::px_ctl_t                     ctl_in,
	input  logic [dfd_pkg::DEPTH_W-1:0]          change_thr,
	input  logic [dfd_pkg::FLAG_THR_W-1:0]       flag_thr,
	output logic                                 res_valid,
	output dfd_pkg::res_t                        res
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int DW = dfd_pkg::DEPTH_W;
	localparam int SW = dfd_pkg::SCORE_W;

	// history entry: previous depth in the upper bits, score in the lower
	logic [DW+SW-1:0] mem [MAX_PIXELS];

	// stage 1: sample, position, raw history read
	logic             v_s1;
	logic [DW-1:0]    depth_s1;
	logic [AW-1:0]    idx_s1;
	dfd_pkg::px_ctl_t ctl_s1;
	logic [DW+SW-1:0] rd_s1;

	// stage 2: change decision
	logic             v_s2;
	logic [DW-1:0]    depth_s2;
	logic [AW-1:0]    idx_s2;
	dfd_pkg::px_ctl_t ctl_s2;
	logic [SW-1:0]    score_s2;
	logic             changed_s2;

	// stage 3: updated score
	logic             v_s3;
	logic [DW-1:0]    depth_s3;
	logic [AW-1:0]    idx_s3;
	dfd_pkg::px_ctl_t ctl_s3;
	logic [SW-1:0]    score_s3;

	logic [DW-1:0] prev_depth;
	logic [SW-1:0] score_fwd1;
	logic [DW:0]   diff_raw;
	logic [DW-1:0] diff;
	logic          cur_ok;
	logic          prev_ok;
	logic          changed;
	logic [SW-1:0] score_old;
	logic [SW-1:0] score_new;

	// stage 1 logic: newer writes still in flight override the memory read
	always_comb begin
		prev_depth = rd_s1[DW+SW-1:SW];
		score_fwd1 = rd_s1[SW-1:0];
		if (v_s2 && idx_s2 == idx_s1) begin
			prev_depth = depth_s2;
		end else if (v_s3 && idx_s3 == idx_s1) begin
			prev_depth = depth_s3;
		end
		if (v_s3 && idx_s3 == idx_s1) begin
			score_fwd1 = score_s3;
		end
		cur_ok   = |depth_s1;
		prev_ok  = |prev_depth;
		diff_raw = {1'b0, depth_s1} - {1'b0, prev_depth};
		diff     = diff_raw[DW] ? (prev_depth - depth_s1) : diff_raw[DW-1:0];
		changed  = (cur_ok != prev_ok) || (cur_ok && diff > change_thr);
	end

	// stage 2 logic: saturating score update, score cleared in the priming frame
	always_comb begin
		score_old = (v_s3 && idx_s3 == idx_s2) ? score_s3 : score_s2;
		if (!ctl_s2.primed) begin
			score_new = '0;
		end else if (changed_s2) begin
			score_new = (score_old == dfd_pkg::SCORE_MAX) ? score_old : score_old + 1'b1;
		end else begin
			score_new = (score_old == '0) ? score_old : score_old - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[idx_in];
		end
		if (v_s2) begin
			mem[idx_s2] <= {depth_s2, score_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		depth_s1   <= depth_in;
		idx_s1     <= idx_in;
		ctl_s1     <= ctl_in;
		depth_s2   <= depth_s1;
		idx_s2     <= idx_s1;
		ctl_s2     <= ctl_s1;
		score_s2   <= score_fwd1;
		changed_s2 <= changed;
		depth_s3   <= depth_s2;
		idx_s3     <= idx_s2;
		ctl_s3     <= ctl_s2;
		score_s3   <= score_new;
	end

	assign res_valid = v_s3;
	assign res.flag  = ctl_s3.primed && (score_s3 >= flag_thr);
	assign res.last  = ctl_s3.last;

endmodule

// ----- rtl/core/dfd_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfd_outq
// Result buffer with in-flight credit count, keeps the pipeline free running.
// ----------------------------------------------------------------------------
module dfd_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	output logic          in_ready,
	input  logic          push,
	input  dfd_pkg::res_t push_data,
	output logic          out_valid,
	input  logic          out_ready,
	output dfd_pkg::res_t out_data
);

	dfd_pkg::res_t                 buf_q [dfd_pkg::OUTQ_DEPTH];
	logic [dfd_pkg::OUTQ_AW-1:0]   wr_ptr_q;
	logic [dfd_pkg::OUTQ_AW-1:0]   rd_ptr_q;
	logic [dfd_pkg::OUTQ_CW-1:0]   cnt_q;
	logic [dfd_pkg::OUTQ_CW-1:0]   credit_q;
	logic                          pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_data  = buf_q[rd_ptr_q];
	// items accepted and not yet delivered never exceed the buffer size
	assign in_ready  = (credit_q < dfd_pkg::OUTQ_CW'(dfd_pkg::OUTQ_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			credit_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q    <= cnt_q + dfd_pkg::OUTQ_CW'(push) - dfd_pkg::OUTQ_CW'(pop);
			credit_q <= credit_q + dfd_pkg::OUTQ_CW'(accept) - dfd_pkg::OUTQ_CW'(pop);
		end
	end

endmodule

// ----- rtl/core/depth_flicker_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_flicker_detector
// Per-pixel depth flicker scoring over consecutive frames.
// ----------------------------------------------------------------------------
// Takes one depth pixel per clock while s_tready is high and returns one
// flag per pixel, in order. Each result passes stages s1, s2 and s3 and is
// then written to the output buffer, which offers it on m_tvalid. The rate is
// set by the single history memory (MAX_PIXELS x 24 bits, one read and one
// write port) that is read on input and written from stage 2; results of the
// last few pixels are forwarded so even tiny frames run at full rate. Up to
// eight pixels may be accepted and not yet delivered, so input keeps flowing
// while results wait. The memory needs no clearing pass: the first frame
// after reset or after a frame width or height write stores depths, clears
// scores and flags nothing. The user must write configuration only while
// idle; the block does not enforce it.
module depth_flicker_detector #(
	parameter int MAX_PIXELS = 524288
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] depth_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] flicker_flag, [7:1] zero
	output logic        m_tlast,   // frame_end
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	logic                              accept;
	logic [AW-1:0]                     idx;
	dfd_pkg::px_ctl_t                  ctl;
	logic [dfd_pkg::DEPTH_W-1:0]       change_thr;
	logic [dfd_pkg::FLAG_THR_W-1:0]    flag_thr;
	logic                              res_valid;
	dfd_pkg::res_t                     res;
	dfd_pkg::res_t                     out_res;

	assign accept = s_tvalid && s_tready;

	dfd_ctrl #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.idx       (idx),
		.ctl       (ctl),
		.change_thr(change_thr),
		.flag_thr  (flag_thr)
	);

	dfd_pipe #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.depth_in  (s_tdata),
		.idx_in    (idx),
		.ctl_in    (ctl),
		.change_thr(change_thr),
		.flag_thr  (flag_thr),
		.res_valid (res_valid),
		.res       (res)
	);

	dfd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_ready (s_tready),
		.push     (res_valid),
		.push_data(res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (out_res)
	);

	assign m_tdata = {7'd0, out_res.flag};
	assign m_tlast = out_res.last;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking stream test of the depth flicker detector.
// ----------------------------------------------------------------------------
// Pixels are queued by the stimulus process and fed by a clocked driver with
// random gaps, while the result side stalls at random. Every accepted pixel
// runs through a local score and history model that yields the expected flag
// and frame end, and each result transfer is checked against the oldest one.
// Registers are rewritten between phases once all results are back. The run
// covers reset sizes, tiny and one-pixel frames, oversized frames, size
// writes in mid-frame, threshold extremes and score saturation.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_PX      = 524288;
	localparam int ITEM_GOAL   = 1700;
	localparam int CALM_FROM   = 1450;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_idx = '0;
	logic [15:0] cfg_wdata = '0;

	depth_flicker_detector #(
		.MAX_PIXELS(MAX_PX)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the detector state and registers
	int unsigned         frame_w, frame_h, chg_thr, flag_thr, px_index;
	bit                  primed;
	bit [15:0]           prev_depth_mem [MAX_PX];
	bit [7:0]            score_mem [MAX_PX];
	dfd_pkg::res_t       expected_q [$];

	bit [15:0]   pixel_q [$];
	bit [15:0]   scene [64];
	bit [1:0]    px_kind [64];
	int unsigned jitter;

	int unsigned gap_pct, stall_pct, in_gap, out_stall;
	bit          calm;
	bit          s_fire;

	int unsigned sent, results, frame_ends, flagged, reg_writes, errors, cycles;

	function automatic dfd_pkg::res_t score_pixel(input bit [15:0] depth);
		int unsigned   total;
		int unsigned   idx;
		int unsigned   diff;
		bit [15:0]     prev;
		bit [7:0]      score;
		bit            changed;
		dfd_pkg::res_t r;
		total = frame_w * frame_h;
		if (total > MAX_PX)
			total = MAX_PX;
		if (total == 0)
			total = 1;
		if (px_index >= total)
			px_index = 0;
		idx = px_index;
		r.last = (idx + 1 == total);
		r.flag = 1'b0;
		if (!primed) begin
			score_mem[idx] = '0;
		end else begin
			prev = prev_depth_mem[idx];
			score = score_mem[idx];
			diff = (depth > prev) ? depth - prev : prev - depth;
			if ((depth != 0) != (prev != 0))
				changed = 1'b1;
			else
				changed = (depth != 0) && (diff > chg_thr);
			if (changed) begin
				if (score != dfd_pkg::SCORE_MAX)
					score++;
			end else if (score != 0) begin
				score--;
			end
			score_mem[idx] = score;
			r.flag = (score >= flag_thr);
		end
		prev_depth_mem[idx] = depth;
		if (r.last) begin
			px_index = 0;
			primed = 1'b1;
		end else begin
			px_index = idx + 1;
		end
		return r;
	endfunction

	task automatic write_reg(input dfd_pkg::cfg_reg_t idx, input bit [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			dfd_pkg::CFG_FRAME_WIDTH: begin
				frame_w = value[10:0];
				primed = 1'b0;
				px_index = 0;
			end
			dfd_pkg::CFG_FRAME_HEIGHT: begin
				frame_h = value[9:0];
				primed = 1'b0;
				px_index = 0;
			end
			dfd_pkg::CFG_CHANGE_THR: chg_thr = value;
			dfd_pkg::CFG_FLAG_THR:   flag_thr = value[7:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// upper data bits beyond the register width are filled with noise
	task automatic set_size(input int unsigned w, input int unsigned h, input bit both);
		bit [15:0] v;
		if (both) begin
			v = 16'($urandom);
			v[10:0] = w[10:0];
			write_reg(dfd_pkg::CFG_FRAME_WIDTH, v);
		end
		v = 16'($urandom);
		v[9:0] = h[9:0];
		write_reg(dfd_pkg::CFG_FRAME_HEIGHT, v);
	endtask

	task automatic new_thresholds();
		bit [15:0] v;
		case ($urandom_range(0, 4))
			0:       v = 16'd0;
			1:       v = 16'hFFFF;
			2:       v = 16'($urandom);
			default: v = 16'($urandom_range(0, 160));
		endcase
		write_reg(dfd_pkg::CFG_CHANGE_THR, v);
		v = 16'($urandom);
		case ($urandom_range(0, 4))
			0:       v[7:0] = 8'd0;
			1:       v[7:0] = 8'hFF;
			2:       v[7:0] = 8'($urandom);
			default: v[7:0] = 8'($urandom_range(1, 6));
		endcase
		write_reg(dfd_pkg::CFG_FLAG_THR, v);
	endtask

	task automatic new_scene();
		foreach (scene[i]) begin
			scene[i] = 16'($urandom_range(1, 65535));
			px_kind[i] = ($urandom_range(0, 5) > 3) ? 2'd0 : 2'($urandom_range(0, 3));
		end
		jitter = $urandom_range(0, 150);
	endtask

	function automatic bit [15:0] next_depth(input int unsigned p, input int unsigned f);
		int v;
		case (px_kind[p])
			2'd0: begin
				// steady surface with noise around the change threshold
				v = int'(scene[p]) + int'($urandom_range(0, 2 * jitter)) - int'(jitter);
				if (v < 0)
					v = 0;
				if (v > 65535)
					v = 65535;
				return 16'(v);
			end
			2'd1: return (f % 2) ? scene[p] : 16'd0;
			2'd2: return 16'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0:       return 16'd0;
					1:       return 16'hFFFF;
					default: return scene[p];
				endcase
			end
		endcase
	endfunction

	task automatic send(input bit [15:0] d);
		pixel_q.push_back(d);
		sent++;
	endtask

	task automatic send_frames(input int unsigned n_px, input int unsigned n_frames);
		for (int unsigned f = 0; f < n_frames; f++)
			for (int unsigned p = 0; p < n_px; p++)
				send(next_depth(p, f));
	endtask

	task automatic pick_idling();
		gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 35);
		stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 35);
	endtask

	// wait until every queued pixel is in and every result is out
	task automatic settle();
		do
			@(posedge clk);
		while (pixel_q.size() != 0 || s_tvalid || expected_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// pixel driver, a new transfer is offered only after the last one went through
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_fire) begin
			if (in_gap != 0) begin
				in_gap--;
				s_tvalid <= 1'b0;
			end else if (pixel_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
				in_gap = $urandom_range(1, 12) - 1;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= pixel_q.pop_front();
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (out_stall != 0) begin
			out_stall--;
			m_tready <= 1'b0;
		end else if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			out_stall = $urandom_range(1, 12) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		dfd_pkg::res_t want;
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_q.size());
			$display("RESULT: ERROR");
			$finish;
		end else if (!arst_n) begin
			s_fire <= 1'b0;
		end else begin
			s_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				expected_q.push_back(score_pixel(s_tdata));
			if (m_tvalid && m_tready) begin
				results++;
				if (m_tlast)
					frame_ends++;
				if (m_tdata[0])
					flagged++;
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result at cycle %0d: tdata %h tlast %b",
							cycles, m_tdata, m_tlast);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata != {7'd0, want.flag} || m_tlast != want.last) begin
						errors++;
						if (errors <= 10)
							$display("result %0d: want flag %b last %b, got %h %b",
								results, want.flag, want.last, m_tdata, m_tlast);
					end
				end
			end
		end
	end

	initial begin
		int unsigned w, h, sel, cur_px;
		bit          big_open;
		frame_w = dfd_pkg::FRAME_WIDTH_RST;
		frame_h = dfd_pkg::FRAME_HEIGHT_RST;
		chg_thr = dfd_pkg::CHANGE_THR_RST;
		flag_thr = dfd_pkg::FLAG_THR_RST;
		px_index = 0;
		primed = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset sizes: a few pixels of the priming frame, no frame end
		pick_idling();
		send(16'd0);
		send(16'hFFFF);
		send(16'd1);
		send(16'h8000);
		settle();

		// 2x2 frames, size write restarts the partly primed frame
		set_size(2, 2, 1'b1);
		write_reg(dfd_pkg::CFG_CHANGE_THR, 16'd0);
		write_reg(dfd_pkg::CFG_FLAG_THR, 16'd0);
		send(16'd0);
		send(16'hFFFF);
		send(16'd1);
		send(16'd100);
		// zero flag threshold: everything flagged, including unchanged invalid
		send(16'd0);
		send(16'd0);
		send(16'hFFFF);
		send(16'd101);
		settle();
		write_reg(dfd_pkg::CFG_CHANGE_THR, 16'hFFFF);
		write_reg(dfd_pkg::CFG_FLAG_THR, 16'h00FF);
		send(16'hFFFF);
		send(16'h5555);
		send(16'hAAAA);
		send(16'd101);
		settle();

		// width of zero gives one-pixel frames
		write_reg(dfd_pkg::CFG_FRAME_WIDTH, 16'hF800);
		send(16'd7);
		send(16'd7);
		send(16'd0);
		settle();

		// largest sizes, frame saturates to the history depth
		write_reg(dfd_pkg::CFG_FRAME_WIDTH, 16'hFFFF);
		write_reg(dfd_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
		send(16'hFFFF);
		send(16'd0);
		send(16'd1);
		send(16'd2);
		send(16'd3);
		settle();

		// single pixel toggling long enough to saturate its score
		set_size(1, 1, 1'b1);
		write_reg(dfd_pkg::CFG_CHANGE_THR, 16'($urandom));
		write_reg(dfd_pkg::CFG_FLAG_THR, {8'($urandom), 8'hFF});
		pick_idling();
		for (int i = 0; i < 300; i++)
			send((i % 2) ? 16'($urandom_range(1, 65535)) : 16'd0);
		repeat (12) send(16'd4321);
		settle();

		big_open = 1'b0;
		cur_px = 1;
		while (sent < ITEM_GOAL) begin
			if (sent >= CALM_FROM)
				calm = 1'b1;
			pick_idling();
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				// oversized or odd frame, only part of the priming pass
				set_size($urandom_range(0, 2047), $urandom_range(0, 1023), 1'b1);
				for (int i = $urandom_range(10, 40); i > 0; i--)
					send(16'($urandom));
				big_open = 1'b1;
			end else if (sel <= 2 && !big_open) begin
				// thresholds change while the stored history stays
				new_thresholds();
				new_scene();
				send_frames(cur_px, $urandom_range(1, 4));
			end else begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 6);
				set_size(w, h, ($urandom_range(0, 3) != 0) || (w != frame_w));
				new_thresholds();
				new_scene();
				cur_px = w * h;
				send_frames(cur_px, $urandom_range(2, 8));
				big_open = 1'b0;
			end
			settle();
		end

		$display("%0d pixels in, %0d results checked, %0d frame ends, %0d flagged",
			sent, results, frame_ends, flagged);
		$display("%0d register writes, %0d mismatches", reg_writes, errors);
		if (errors == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
